// ===== hw/rtl/sbbp_pkg.sv =====
`timescale 1ns / 1ps

package sbbp_pkg;

  // Shared divider operand widths: dividend covers 63 * 255, divisor covers a band count.
  localparam int unsigned DIV_W    = 16;
  localparam int unsigned DVS_W    = 8;
  localparam int unsigned DIV_CNTW = $clog2(DIV_W);

  // Default strip geometry.
  localparam int unsigned LED_COUNT_DEF = 64;
  localparam int unsigned MAX_BANDS_DEF = 32;

  // Color wheel constants.
  localparam logic [7:0] FULL_SCALE = 8'd255;
  localparam logic [7:0] SEG_SPAN   = 8'd85;
  localparam logic [7:0] SEG_SPAN2  = 8'd170;

  typedef struct packed {
    logic             go;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
  } div_rsp_t;

endpackage

// ===== hw/rtl/sbbp_div.sv =====
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module sbbp_div (
  input  logic               clk,
  input  logic               rst_n,
  input  sbbp_pkg::div_req_t req,
  output sbbp_pkg::div_rsp_t rsp
);
  import sbbp_pkg::*;

  logic                busy_r;
  logic                done_r;
  logic [DIV_CNTW-1:0] cnt_r;
  logic [DIV_W-1:0]    quo_r;   // dividend shifts out the top, quotient in the bottom
  logic [DVS_W-1:0]    rem_r;
  logic [DVS_W-1:0]    dvs_r;

  logic [DVS_W:0]      rem_sh;
  logic                ge;
  logic [DVS_W:0]      rem_diff;
  logic [DVS_W-1:0]    rem_nxt;

  always_comb begin
    rem_sh   = {rem_r, quo_r[DIV_W-1]};
    ge       = (rem_sh >= {1'b0, dvs_r});
    rem_diff = rem_sh - {1'b0, dvs_r};
    rem_nxt  = ge ? rem_diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.go) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        quo_r  <= req.dividend;
        rem_r  <= '0;
        dvs_r  <= req.divisor;
      end else if (busy_r) begin
        quo_r <= {quo_r[DIV_W-2:0], ge};
        rem_r <= rem_nxt;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNTW'(DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;

endmodule

// ===== hw/rtl/spectrum_band_bar_painter_top.sv =====
`timescale 1ns / 1ps

// Spectrum band bar painter.
//
// Input stream: one transfer per frequency band. in_tdata carries the band
// index, level and band count; in_tuser selects solid (1) or rainbow (0) color.
// Output stream: one transfer per LED of the band's zone, in rising LED order,
// with out_tlast on the final LED of the zone. Bands with a bad count, an index
// outside the frame or a zone off the strip produce no transfers.
//
// Divides by the band count share one restoring divider. Divides by 255 use an
// add-and-shift reciprocal, one per cycle. Solid bands need the zone-width
// divide and the bar-height step before the first LED leaves; rainbow bands
// add the hue divide and three channel scales. LEDs then stream at one per
// cycle while the receiver accepts them. in_tready is high only while idle.
// A stalled receiver holds the output register and pauses the LED walk.
// Reset (rst_n low, synchronous) returns the sequencer to idle and drops
// out_tvalid; nothing else is kept between bands.
module spectrum_band_bar_painter_top #(
  parameter int unsigned LED_COUNT = sbbp_pkg::LED_COUNT_DEF,
  parameter int unsigned MAX_BANDS = sbbp_pkg::MAX_BANDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // band_index[5:0], band_level[13:6], band_count[19:14], zero
  input  logic        in_tuser,   // solid_mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // led_index[5:0], red[13:6], green[21:14], blue[29:22], zero
  output logic        out_tlast   // last_of_zone
);
  import sbbp_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WIDTH,
    ST_BAR,
    ST_HUE,
    ST_SCALE,
    ST_EMIT
  } state_t;

  // Sequencer and band registers.
  state_t           state_r, state_nxt;
  logic [5:0]       idx_r, idx_nxt;
  logic [7:0]       level_r, level_nxt;
  logic [5:0]       count_r, count_nxt;
  logic             solid_r, solid_nxt;
  logic [6:0]       width_r, width_nxt;
  logic [6:0]       bar_r, bar_nxt;
  logic [6:0]       end_r, end_nxt;
  logic [5:0]       pos_r, pos_nxt;
  logic [5:0]       offs_r, offs_nxt;
  logic [1:0]       ch_r, ch_nxt;
  logic [7:0]       col_r [3];
  logic [7:0]       col_nxt [3];

  // Divider request registers.
  logic             go_r, go_nxt;
  logic [DIV_W-1:0] dvd_r, dvd_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  // Output register.
  logic             out_tvalid_r, out_tvalid_nxt;
  logic [5:0]       out_led_r, out_led_nxt;
  logic [7:0]       out_red_r, out_red_nxt;
  logic [7:0]       out_grn_r, out_grn_nxt;
  logic [7:0]       out_blu_r, out_blu_nxt;
  logic             out_last_r, out_last_nxt;

  // Input unpack.
  logic [5:0]       in_idx;
  logic [7:0]       in_level;
  logic [5:0]       in_count;
  logic             in_fire;
  logic             in_bad;

  // Datapath helpers.
  logic [6:0]       w_q;
  logic [12:0]      start_full;
  logic [6:0]       end_sum;
  logic [14:0]      lvl_w;
  logic [7:0]       bar_q;
  logic [DIV_W-1:0] hue_dvd;
  logic [7:0]       hue;
  logic [7:0]       hrem;
  logic [8:0]       ramp_full;
  logic [7:0]       ramp;
  logic [DIV_W-1:0] chan_prod;
  logic [7:0]       chan_q;
  logic             lit;
  logic             last;

  // floor(x / 255) for x up to 255 * 255: (x + (x >> 8) + 1) >> 8.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] s;
    s = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
    return s[15:8];
  endfunction

  assign in_idx   = in_tdata[5:0];
  assign in_level = in_tdata[13:6];
  assign in_count = in_tdata[19:14];
  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign in_bad    = (in_count == 6'd0) || ({1'b0, in_count} > 7'(MAX_BANDS)) ||
                     (in_idx >= in_count);

  // Zone width from the divider, floored at one.
  assign w_q        = (div_rsp.quot == '0) ? 7'd1 : div_rsp.quot[6:0];
  assign start_full = idx_r * w_q;
  assign end_sum    = start_full[6:0] + w_q;

  // Bar height = level * width / 255.
  assign lvl_w = level_r * width_r;
  assign bar_q = div255({1'b0, lvl_w});

  // idx * 255 as a shift and subtract.
  assign hue_dvd = {2'b00, idx_r, 8'd0} - {10'd0, idx_r};

  // Hue wheel: segment select and ramp = (hue mod 85) * 3.
  assign hue = div_rsp.quot[7:0];
  always_comb begin
    if (hue >= SEG_SPAN2) begin
      hrem = hue - SEG_SPAN2;
    end else if (hue >= SEG_SPAN) begin
      hrem = hue - SEG_SPAN;
    end else begin
      hrem = hue;
    end
  end
  assign ramp_full = {hrem, 1'b0} + {1'b0, hrem};
  assign ramp      = ramp_full[7:0];

  // One channel scaled by level / 255 per cycle.
  assign chan_prod = col_r[ch_r] * level_r;
  assign chan_q    = div255(chan_prod);

  assign lit  = ({1'b0, offs_r} < bar_r);
  assign last = (({1'b0, pos_r} + 7'd1) == end_r);

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    level_nxt      = level_r;
    count_nxt      = count_r;
    solid_nxt      = solid_r;
    width_nxt      = width_r;
    bar_nxt        = bar_r;
    end_nxt        = end_r;
    pos_nxt        = pos_r;
    offs_nxt       = offs_r;
    ch_nxt         = ch_r;
    col_nxt        = col_r;
    go_nxt         = 1'b0;
    dvd_nxt        = dvd_r;
    dvs_nxt        = dvs_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_led_nxt    = out_led_r;
    out_red_nxt    = out_red_r;
    out_grn_nxt    = out_grn_r;
    out_blu_nxt    = out_blu_r;
    out_last_nxt   = out_last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          idx_nxt   = in_idx;
          level_nxt = in_level;
          count_nxt = in_count;
          solid_nxt = in_tuser;
          if (!in_bad) begin
            go_nxt    = 1'b1;
            dvd_nxt   = DIV_W'(LED_COUNT);
            dvs_nxt   = {2'b00, in_count};
            state_nxt = ST_WIDTH;
          end
        end
      end
      ST_WIDTH: begin
        if (div_rsp.done) begin
          if (start_full >= 13'(LED_COUNT)) begin
            state_nxt = ST_IDLE;  // zone starts off the strip
          end else begin
            width_nxt = w_q;
            pos_nxt   = start_full[5:0];
            offs_nxt  = 6'd0;
            end_nxt   = (end_sum > 7'(LED_COUNT)) ? 7'(LED_COUNT) : end_sum;
            state_nxt = ST_BAR;
          end
        end
      end
      ST_BAR: begin
        bar_nxt = (bar_q > {1'b0, width_r}) ? width_r : bar_q[6:0];
        if (solid_r) begin
          col_nxt[0] = level_r;
          col_nxt[1] = level_r;
          col_nxt[2] = level_r;
          state_nxt  = ST_EMIT;
        end else begin
          go_nxt    = 1'b1;
          dvd_nxt   = hue_dvd;
          dvs_nxt   = {2'b00, count_r};
          state_nxt = ST_HUE;
        end
      end
      ST_HUE: begin
        if (div_rsp.done) begin
          if (hue >= SEG_SPAN2) begin
            col_nxt[0] = ramp;
            col_nxt[1] = FULL_SCALE - ramp;
            col_nxt[2] = FULL_SCALE;
          end else if (hue >= SEG_SPAN) begin
            col_nxt[0] = FULL_SCALE - ramp;
            col_nxt[1] = FULL_SCALE;
            col_nxt[2] = ramp;
          end else begin
            col_nxt[0] = FULL_SCALE;
            col_nxt[1] = ramp;
            col_nxt[2] = 8'd0;
          end
          ch_nxt    = 2'd0;
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE: begin
        col_nxt[ch_r] = chan_q;
        if (ch_r == 2'd2) begin
          state_nxt = ST_EMIT;
        end else begin
          ch_nxt = ch_r + 2'd1;
        end
      end
      ST_EMIT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_led_nxt    = pos_r;
          out_red_nxt    = lit ? col_r[0] : 8'd0;
          out_grn_nxt    = lit ? col_r[1] : 8'd0;
          out_blu_nxt    = lit ? col_r[2] : 8'd0;
          out_last_nxt   = last;
          pos_nxt        = pos_r + 6'd1;
          offs_nxt       = offs_r + 6'd1;
          if (last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      go_r         <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      go_r         <= go_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    idx_r      <= idx_nxt;
    level_r    <= level_nxt;
    count_r    <= count_nxt;
    solid_r    <= solid_nxt;
    width_r    <= width_nxt;
    bar_r      <= bar_nxt;
    end_r      <= end_nxt;
    pos_r      <= pos_nxt;
    offs_r     <= offs_nxt;
    ch_r       <= ch_nxt;
    col_r      <= col_nxt;
    dvd_r      <= dvd_nxt;
    dvs_r      <= dvs_nxt;
    out_led_r  <= out_led_nxt;
    out_red_r  <= out_red_nxt;
    out_grn_r  <= out_grn_nxt;
    out_blu_r  <= out_blu_nxt;
    out_last_r <= out_last_nxt;
  end

  assign div_req.go       = go_r;
  assign div_req.dividend = dvd_r;
  assign div_req.divisor  = dvs_r;

  sbbp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {2'b00, out_blu_r, out_grn_r, out_red_r, out_led_r};
  assign out_tlast  = out_last_r;

  // A divide result only comes back while the sequencer waits for one.
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == ST_WIDTH || state_r == ST_HUE))
    else $error("divider result outside a wait state");

  // The LED walk stays inside the zone and on the strip.
  a_walk_in_zone: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (({1'b0, offs_r} < width_r) && ({1'b0, pos_r} < end_r)))
    else $error("LED walk left its zone");

  a_end_on_strip: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (end_r <= 7'(LED_COUNT)))
    else $error("zone end beyond strip");

  a_bar_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (bar_r <= width_r))
    else $error("bar taller than zone");

endmodule
